// File: hw/rtl/gse_pkg.sv
// gse_pkg: shared types and constants for the gnome sort engine
// beat structs, microcode control word, status flags and step names
// no dependencies
`default_nettype none

package gse_pkg;

    localparam int unsigned DATA_W = 32;

    // input beat: one element of the set
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_beat_t;

    // result beat: one sorted element
    typedef struct packed {
        logic signed [DATA_W-1:0] sorted_value;
        logic                     final_res;
    } out_beat_t;

    // microprogram step addresses
    typedef enum logic [3:0] {
        U_LOAD = 4'd0,
        U_INIT = 4'd1,
        U_CHK  = 4'd2,
        U_RDA  = 4'd3,
        U_CMP  = 4'd4,
        U_INC  = 4'd5,
        U_SWP1 = 4'd6,
        U_SWP2 = 4'd7,
        U_ERD  = 4'd8,
        U_EPUT = 4'd9,
        U_ENXT = 4'd10,
        U_DONE = 4'd11
    } upc_t;

    // jump conditions
    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NOT_ACC_LAST,
        C_POS_GE_N,
        C_OUT_OF_ORDER,
        C_OUT_BUSY,
        C_K_LT_N
    } cond_t;

    // store read address select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS_M1,
        RD_POS,
        RD_K
    } rd_sel_t;

    // store write select (swap halves)
    typedef enum logic [1:0] {
        WR_NONE,
        WR_LO_B,
        WR_HI_A
    } wr_sel_t;

    // position register operation
    typedef enum logic [1:0] {
        POS_HOLD,
        POS_SET1,
        POS_INC,
        POS_DEC
    } pos_op_t;

    // one microcode control word
    typedef struct packed {
        cond_t   cond;
        upc_t    target;
        rd_sel_t rd_sel;
        wr_sel_t wr_sel;
        pos_op_t pos_op;
        logic    in_rdy;
        logic    latch_a;
        logic    latch_b;
        logic    emit;
        logic    k_clr;
        logic    cnt_clr;
    } ctrl_t;

    // datapath status seen by the sequencer
    typedef struct packed {
        logic acc_last;
        logic pos_ge_n;
        logic out_of_order;
        logic out_busy;
        logic k_lt_n;
    } stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/gse_ucode_rom.sv
// gse_ucode_rom: read-only microprogram, one control word per step
// depends on gse_pkg
`default_nettype none

module gse_ucode_rom (
    input  gse_pkg::upc_t  upc,
    output gse_pkg::ctrl_t ctrl
);

    // program table
    always_comb begin
        ctrl         = '0;
        ctrl.cond    = gse_pkg::C_NEVER;
        ctrl.target  = gse_pkg::U_LOAD;
        ctrl.rd_sel  = gse_pkg::RD_NONE;
        ctrl.wr_sel  = gse_pkg::WR_NONE;
        ctrl.pos_op  = gse_pkg::POS_HOLD;
        case (upc)
            // collect beats until one flagged last
            gse_pkg::U_LOAD: begin
                ctrl.in_rdy = 1'b1;
                ctrl.cond   = gse_pkg::C_NOT_ACC_LAST;
                ctrl.target = gse_pkg::U_LOAD;
            end
            gse_pkg::U_INIT: begin
                ctrl.pos_op = gse_pkg::POS_SET1;
                ctrl.k_clr  = 1'b1;
            end
            // loop head: done when pos reaches n, else fetch lower neighbour
            gse_pkg::U_CHK: begin
                ctrl.cond   = gse_pkg::C_POS_GE_N;
                ctrl.target = gse_pkg::U_ERD;
                ctrl.rd_sel = gse_pkg::RD_POS_M1;
            end
            gse_pkg::U_RDA: begin
                ctrl.latch_a = 1'b1;
                ctrl.rd_sel  = gse_pkg::RD_POS;
            end
            gse_pkg::U_CMP: begin
                ctrl.latch_b = 1'b1;
                ctrl.cond    = gse_pkg::C_OUT_OF_ORDER;
                ctrl.target  = gse_pkg::U_SWP1;
            end
            gse_pkg::U_INC: begin
                ctrl.pos_op = gse_pkg::POS_INC;
                ctrl.cond   = gse_pkg::C_ALWAYS;
                ctrl.target = gse_pkg::U_CHK;
            end
            // swap over two writes, then step back
            gse_pkg::U_SWP1: begin
                ctrl.wr_sel = gse_pkg::WR_LO_B;
            end
            gse_pkg::U_SWP2: begin
                ctrl.wr_sel = gse_pkg::WR_HI_A;
                ctrl.pos_op = gse_pkg::POS_DEC;
                ctrl.cond   = gse_pkg::C_ALWAYS;
                ctrl.target = gse_pkg::U_CHK;
            end
            // emission loop
            gse_pkg::U_ERD: begin
                ctrl.rd_sel = gse_pkg::RD_K;
            end
            gse_pkg::U_EPUT: begin
                ctrl.emit   = 1'b1;
                ctrl.cond   = gse_pkg::C_OUT_BUSY;
                ctrl.target = gse_pkg::U_EPUT;
            end
            gse_pkg::U_ENXT: begin
                ctrl.cond   = gse_pkg::C_K_LT_N;
                ctrl.target = gse_pkg::U_ERD;
            end
            gse_pkg::U_DONE: begin
                ctrl.cnt_clr = 1'b1;
                ctrl.cond    = gse_pkg::C_ALWAYS;
                ctrl.target  = gse_pkg::U_LOAD;
            end
            default: begin
                ctrl.cond   = gse_pkg::C_ALWAYS;
                ctrl.target = gse_pkg::U_LOAD;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/gse_sequencer.sv
// gse_sequencer: step counter with conditional jumps
// depends on gse_pkg
`default_nettype none

module gse_sequencer (
    input  wire            aclk,
    input  wire            aresetn,
    input  gse_pkg::ctrl_t ctrl,
    input  gse_pkg::stat_t stat,
    output gse_pkg::upc_t  upc
);

    gse_pkg::upc_t upc_reg;
    gse_pkg::upc_t upc_next;
    logic          jump;

    // condition select
    always_comb begin
        case (ctrl.cond)
            gse_pkg::C_NEVER:        jump = 1'b0;
            gse_pkg::C_ALWAYS:       jump = 1'b1;
            gse_pkg::C_NOT_ACC_LAST: jump = !stat.acc_last;
            gse_pkg::C_POS_GE_N:     jump = stat.pos_ge_n;
            gse_pkg::C_OUT_OF_ORDER: jump = stat.out_of_order;
            gse_pkg::C_OUT_BUSY:     jump = stat.out_busy;
            gse_pkg::C_K_LT_N:       jump = stat.k_lt_n;
            default:                 jump = 1'b1;
        endcase
    end

    // next step
    always_comb begin
        if (jump) begin
            upc_next = ctrl.target;
        end else begin
            upc_next = gse_pkg::upc_t'(upc_reg + 4'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= gse_pkg::U_LOAD;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign upc = upc_reg;

    // loading only leaves on a last beat
    a_load_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == gse_pkg::U_LOAD && !stat.acc_last) |=> (upc_reg == gse_pkg::U_LOAD))
        else $error("load step left without a last beat");

    // a swap always follows an out-of-order compare
    a_swap_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (upc_reg == gse_pkg::U_SWP1) |-> ($past(upc_reg) == gse_pkg::U_CMP))
        else $error("swap entered from outside compare");

    // the step counter stays on programmed steps
    a_upc_range: assert property (@(posedge aclk) disable iff (!aresetn)
        upc_reg <= gse_pkg::U_DONE)
        else $error("step counter off program");

endmodule

`default_nettype wire

// File: hw/rtl/gse_datapath.sv
// gse_datapath: element store, position and emit counters, compare and result register
// depends on gse_pkg
`default_nettype none

module gse_datapath #(
    parameter int unsigned DEPTH = 64
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  gse_pkg::ctrl_t    ctrl,
    output gse_pkg::stat_t    stat,
    input  wire               s_valid,
    output logic              s_ready,
    input  gse_pkg::in_beat_t s_data,
    output logic              m_valid,
    input  wire               m_ready,
    output gse_pkg::out_beat_t m_data
);

    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

    logic signed [gse_pkg::DATA_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [CNT_W-1:0]                  pos_reg, pos_next;
    logic [CNT_W-1:0]                  k_reg, k_next;
    logic signed [gse_pkg::DATA_W-1:0] a_reg, b_reg, rd_data_reg;
    logic                              m_valid_reg, m_valid_next;
    gse_pkg::out_beat_t                m_data_reg;

    logic                              s_acc;
    logic                              has_room;
    logic                              out_free;
    logic                              out_fire;
    logic                              wr_en;
    logic [ADDR_W-1:0]                 wr_addr;
    logic signed [gse_pkg::DATA_W-1:0] wr_data;
    logic                              rd_en;
    logic [ADDR_W-1:0]                 rd_addr;
    logic [CNT_W-1:0]                  pos_m1;

    assign s_ready  = ctrl.in_rdy;
    assign s_acc    = s_valid && ctrl.in_rdy;
    assign has_room = (count_reg < CNT_W'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;
    assign out_fire = ctrl.emit && out_free;
    assign pos_m1   = pos_reg - CNT_W'(1);

    // status towards the sequencer
    always_comb begin
        stat.acc_last     = s_acc && s_data.last;
        stat.pos_ge_n     = (pos_reg >= count_reg);
        stat.out_of_order = (a_reg > rd_data_reg);
        stat.out_busy     = !out_free;
        stat.k_lt_n       = (k_reg < count_reg);
    end

    // store write port: load beat or one half of a swap
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = count_reg[ADDR_W-1:0];
        wr_data = s_data.value;
        case (ctrl.wr_sel)
            gse_pkg::WR_LO_B: begin
                wr_en   = 1'b1;
                wr_addr = pos_m1[ADDR_W-1:0];
                wr_data = b_reg;
            end
            gse_pkg::WR_HI_A: begin
                wr_en   = 1'b1;
                wr_addr = pos_reg[ADDR_W-1:0];
                wr_data = a_reg;
            end
            default: begin
                wr_en = s_acc && has_room;
            end
        endcase
    end

    // store read port
    always_comb begin
        rd_en   = 1'b1;
        rd_addr = pos_reg[ADDR_W-1:0];
        case (ctrl.rd_sel)
            gse_pkg::RD_POS_M1: rd_addr = pos_m1[ADDR_W-1:0];
            gse_pkg::RD_POS:    rd_addr = pos_reg[ADDR_W-1:0];
            gse_pkg::RD_K:      rd_addr = k_reg[ADDR_W-1:0];
            default:            rd_en   = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // fill count, saturating at the store depth
    always_comb begin
        count_next = count_reg;
        if (ctrl.cnt_clr) begin
            count_next = '0;
        end else if (s_acc && has_room) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    // sort position
    always_comb begin
        case (ctrl.pos_op)
            gse_pkg::POS_SET1: pos_next = CNT_W'(1);
            gse_pkg::POS_INC:  pos_next = pos_reg + CNT_W'(1);
            gse_pkg::POS_DEC:  pos_next = (pos_reg == CNT_W'(1)) ? pos_reg : pos_m1;
            default:           pos_next = pos_reg;
        endcase
    end

    // emit index
    always_comb begin
        k_next = k_reg;
        if (ctrl.k_clr) begin
            k_next = '0;
        end else if (out_fire) begin
            k_next = k_reg + CNT_W'(1);
        end
    end

    // result register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            pos_reg     <= '0;
            k_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            k_reg       <= k_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // compare operands and result payload
    always_ff @(posedge aclk) begin
        if (ctrl.latch_a) begin
            a_reg <= rd_data_reg;
        end
        if (ctrl.latch_b) begin
            b_reg <= rd_data_reg;
        end
        if (out_fire) begin
            m_data_reg.sorted_value <= rd_data_reg;
            m_data_reg.final_res    <= ((k_reg + CNT_W'(1)) == count_reg);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // fill count never passes the depth
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count beyond depth");

    // a beat is only emitted for a stored element
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_fire |-> (k_reg < count_reg))
        else $error("emit past the end of the set");

    // swaps never touch the entry below zero
    a_swap_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.wr_sel != gse_pkg::WR_NONE) |-> (pos_reg != '0 && pos_reg < count_reg))
        else $error("swap at invalid position");

endmodule

`default_nettype wire

// File: hw/rtl/gnome_sort_engine_top.sv
// Gnome sort engine. Input beats carry one signed 32-bit value each and are
// taken one per cycle into an internal store of DEPTH entries; beats beyond
// DEPTH are dropped, and a beat flagged last closes the set. s_ready then
// falls while a microcoded sequencer gnome-sorts the store in place through
// a single-port-read, single-port-write memory: each neighbour check reads
// and compares two adjacent entries, and each swap writes both back and
// steps back one position. The sorted values then leave on the m_ channel
// in ascending order, one beat per pass through the read, put and next
// steps of the emission loop, the put step waiting while the output
// register is still full, with final_res high on the largest. s_ready
// rises again once the next and done steps have followed the loading of the
// last beat into the output register. Equal values keep their arrival order.
// depends on gse_pkg, gse_ucode_rom, gse_sequencer, gse_datapath
`default_nettype none

module gnome_sort_engine_top #(
    parameter int unsigned DEPTH = 64
) (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                s_valid,
    output logic               s_ready,
    input  gse_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  wire                m_ready,
    output gse_pkg::out_beat_t m_data
);

    gse_pkg::upc_t  upc;
    gse_pkg::ctrl_t ctrl;
    gse_pkg::stat_t stat;

    // microprogram store
    gse_ucode_rom u_rom (
        .upc  (upc),
        .ctrl (ctrl)
    );

    // step counter
    gse_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .upc     (upc)
    );

    // store and arithmetic
    gse_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .stat    (stat),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
